// ----- src/lnorm_pkg.sv -----
// Shared types and constants for the layer normalization engine.
package lnorm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 12;
  localparam int EPS_W     = 16;
  localparam int SUM_W     = 28;
  localparam int MEAN_W    = 17;
  localparam int DIFF_W    = 18;
  localparam int SQ_W      = 33;
  localparam int ACC_W     = 44;
  localparam int INV_W     = 32;
  localparam int DVD_W     = 64;
  localparam int DVR_W     = 33;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_VAR_WALK,
    S_VAR_GO,
    S_VAR_WAIT,
    S_INV_GO,
    S_INV_WAIT,
    S_ROOT,
    S_EMIT_RD,
    S_EMIT_MUL,
    S_EMIT_NORM,
    S_EMIT_OUT
  } state_t;

endpackage

// ----- src/layer_normalization_engine.sv -----
// Layer normalization engine: sample buffer, statistics pass and emit datapath.
//
// A load beat never raises busy. An emit beat on a full vector holds busy
// through the buffer read, two registered multiplies and the round and
// saturate step, and its result appears in the same cycle that busy falls.
// The first emit of a vector also runs the statistics pass first: the
// one-bit-per-cycle divider used up to three times (mean, variance,
// reciprocal) and the 32-step square root, plus the walk over the n stored
// samples through the buffer's single read port. An emit before the vector
// is full answers with status not ready on the next cycle. Results are
// held for exactly one cycle under strobe; the receiver cannot stall them.
// Write configuration only while busy is low.
module layer_normalization_engine #(
  parameter int MAX_LENGTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic signed [lnorm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [lnorm_pkg::SAMPLE_W-1:0] gain,
  input  logic signed [lnorm_pkg::SAMPLE_W-1:0] offset,
  output logic                           strobe,
  output logic signed [lnorm_pkg::SAMPLE_W-1:0] normalized,
  output logic                           final_element,
  output logic                           status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lnorm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnorm_pkg::EPS_W-1:0]    cfg_data
);
  import lnorm_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int EW = (CW > LEN_W) ? CW : LEN_W;

  state_t state, state_next;

  logic [LEN_W-1:0]  vector_length;
  logic [EPS_W-1:0]  epsilon;
  logic [CW-1:0]     loaded_count;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [MEAN_W-1:0] mean_value;
  logic [INV_W-1:0]  inverse_deviation;
  logic              stats_ready;
  logic [CW-1:0]     emit_index;

  logic [EW-1:0]     len_ext;
  logic [CW-1:0]     eff_len;
  logic              full;
  logic              accept;
  logic              cfg_wr;

  // statistics walk
  logic [CW-1:0]     walk_idx;
  logic              rd_vld;
  logic              sq_vld;
  logic [SQ_W-1:0]   sq;
  logic [ACC_W-1:0]  acc;
  logic [DVR_W-1:0]  var_eps;

  // root
  logic [DVD_W-1:0]  rad;
  logic [DVR_W:0]    rrem;
  logic [INV_W-1:0]  root;
  logic [4:0]        root_cnt;
  logic [DVR_W:0]    rrem_sh;
  logic [DVR_W:0]    rtrial;

  // divider
  logic              div_go;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVR_W-1:0]  div_dvr;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;

  // buffer
  logic [AW-1:0]     raddr;
  logic signed [SAMPLE_W-1:0] rdata;

  // emit datapath
  logic signed [SAMPLE_W-1:0] gain_q;
  logic signed [SAMPLE_W-1:0] offset_q;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [50:0]         prod1;
  logic [50:0]                mag1;
  logic [30:0]                r1;
  logic signed [31:0]         norm;
  logic signed [47:0]         prod2;
  logic [47:0]                mag2;
  logic [35:0]                r2;
  logic signed [36:0]         r2s;
  logic signed [37:0]         y;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       last;
  logic [SUM_W-1:0]           sum_mag;

  assign len_ext = EW'(vector_length);
  always_comb begin
    if (vector_length == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > EW'(MAX_LENGTH)) begin
      eff_len = CW'(MAX_LENGTH);
    end else begin
      eff_len = len_ext[CW-1:0];
    end
  end

  assign full   = loaded_count >= eff_len;
  assign accept = start && !busy;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign last   = (emit_index + 1'b1) >= eff_len;

  assign sum_mag = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  assign var_eps = DVR_W'(div_q[DVR_W-1:0]) + DVR_W'(epsilon);

  lnorm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_store (
    .clk  (clk),
    .we   (accept && opcode == OP_LOAD && !full),
    .waddr(loaded_count[AW-1:0]),
    .wdata(sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  lnorm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(div_dvd),
    .divisor (div_dvr),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && opcode == OP_EMIT && full) begin
          state_next = stats_ready ? S_EMIT_RD : S_MEAN_GO;
        end
      end
      S_MEAN_GO:   state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_done) state_next = S_VAR_WALK;
      S_VAR_WALK: begin
        if (walk_idx == loaded_count && !rd_vld && !sq_vld) state_next = S_VAR_GO;
      end
      S_VAR_GO:    state_next = S_VAR_WAIT;
      S_VAR_WAIT:  if (div_done) state_next = S_INV_GO;
      S_INV_GO:    state_next = (var_eps == '0) ? S_EMIT_RD : S_INV_WAIT;
      S_INV_WAIT:  if (div_done) state_next = S_ROOT;
      S_ROOT:      if (root_cnt == 5'd0) state_next = S_EMIT_RD;
      S_EMIT_RD:   state_next = S_EMIT_MUL;
      S_EMIT_MUL:  state_next = S_EMIT_NORM;
      S_EMIT_NORM: state_next = S_EMIT_OUT;
      S_EMIT_OUT:  state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    busy      = state != S_IDLE;
    cfg_ready = state == S_IDLE;
    div_go    = 1'b0;
    div_dvd   = DVD_W'(sum_mag) + DVD_W'(eff_len >> 1);
    div_dvr   = DVR_W'(eff_len);
    raddr     = emit_index[AW-1:0];
    case (state)
      S_MEAN_GO: div_go = 1'b1;
      S_VAR_WALK: raddr = walk_idx[AW-1:0];
      S_VAR_GO: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(acc);
      end
      S_INV_GO: begin
        div_go  = var_eps != '0;
        div_dvd = '1;
        div_dvr = var_eps;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and vector bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length     <= LEN_W'(2048);
      epsilon           <= EPS_W'(168);
      loaded_count      <= '0;
      running_sum       <= '0;
      stats_ready       <= 1'b0;
      emit_index        <= '0;
      mean_value        <= '0;
      inverse_deviation <= '0;
    end else begin
      if (cfg_wr && cfg_index == CFG_LENGTH) begin
        vector_length <= cfg_data[LEN_W-1:0];
        loaded_count  <= '0;
        running_sum   <= '0;
        stats_ready   <= 1'b0;
        emit_index    <= '0;
      end else if (cfg_wr && cfg_index == CFG_EPSILON) begin
        epsilon <= cfg_data;
      end
      if (accept && opcode == OP_LOAD && !full) begin
        loaded_count <= loaded_count + 1'b1;
        running_sum  <= running_sum + SUM_W'(sample);
      end
      if (state == S_MEAN_WAIT && div_done) begin
        mean_value <= running_sum[SUM_W-1] ? -$signed(div_q[MEAN_W-1:0])
                                           : $signed(div_q[MEAN_W-1:0]);
      end
      if (state == S_INV_GO && var_eps == '0) begin
        inverse_deviation <= '1;
        stats_ready       <= 1'b1;
      end
      if (state == S_ROOT && root_cnt == 5'd0) begin
        inverse_deviation <= rtrial <= rrem_sh ? {root[INV_W-2:0], 1'b1}
                                              : {root[INV_W-2:0], 1'b0};
        stats_ready       <= 1'b1;
      end
      if (state == S_EMIT_OUT) begin
        if (last) begin
          loaded_count <= '0;
          running_sum  <= '0;
          stats_ready  <= 1'b0;
          emit_index   <= '0;
        end else begin
          emit_index <= emit_index + 1'b1;
        end
      end
    end
  end

  // variance walk: read, square, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      rd_vld <= state == S_VAR_WALK && walk_idx != loaded_count;
      sq_vld <= rd_vld;
    end
  end

  assign diff = DIFF_W'(rdata) - DIFF_W'(mean_value);

  always_ff @(posedge clk) begin
    if (state == S_MEAN_WAIT) begin
      walk_idx <= '0;
      acc      <= '0;
    end else if (state == S_VAR_WALK) begin
      if (walk_idx != loaded_count) walk_idx <= walk_idx + 1'b1;
      if (sq_vld) acc <= acc + ACC_W'(sq);
    end
    sq <= SQ_W'(diff * diff);
  end

  // square root, two radicand bits a step
  assign rrem_sh = {rrem[DVR_W-2:0], rad[DVD_W-1:DVD_W-2]};
  assign rtrial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (state == S_INV_WAIT) begin
      rad      <= div_q;
      rrem     <= '0;
      root     <= '0;
      root_cnt <= 5'd31;
    end else if (state == S_ROOT) begin
      rad      <= {rad[DVD_W-3:0], 2'b00};
      root_cnt <= root_cnt - 1'b1;
      if (rtrial <= rrem_sh) begin
        rrem <= rrem_sh - rtrial;
        root <= {root[INV_W-2:0], 1'b1};
      end else begin
        rrem <= rrem_sh;
        root <= {root[INV_W-2:0], 1'b0};
      end
    end
  end

  // emit datapath
  assign mag1 = prod1[50] ? 51'(-prod1) : 51'(prod1);
  assign r1   = 31'((mag1 + 51'(1 << 19)) >> 20);
  assign norm = prod1[50] ? -$signed({1'b0, r1}) : $signed({1'b0, r1});
  assign mag2 = prod2[47] ? 48'(-prod2) : 48'(prod2);
  assign r2   = 36'((mag2 + 48'(1 << 11)) >> 12);
  assign r2s  = prod2[47] ? -$signed({1'b0, r2}) : $signed({1'b0, r2});
  assign y    = 38'(r2s) + 38'(offset_q);

  always_comb begin
    if (y > 38'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -38'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_EMIT) begin
      gain_q   <= gain;
      offset_q <= offset;
    end
    if (state == S_EMIT_MUL) prod1 <= 51'(diff) * $signed({1'b0, inverse_deviation});
    if (state == S_EMIT_NORM) prod2 <= 48'(norm) * 48'(gain_q);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (accept && opcode == OP_EMIT && !full) || state == S_EMIT_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_EMIT && !full) begin
      normalized    <= '0;
      final_element <= 1'b0;
      status        <= STATUS_NOT_READY;
    end else if (state == S_EMIT_OUT) begin
      normalized    <= y_sat;
      final_element <= last;
      status        <= STATUS_OK;
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == S_EMIT_OUT || ($past(accept) && $past(opcode) == OP_EMIT)))
    else $error("result strobe without a source");
  a_not_ready_flags: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == STATUS_NOT_READY) |-> (!final_element && normalized == '0))
    else $error("not-ready result carries data");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= eff_len)
    else $error("loaded count beyond vector length");
  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD) |-> (full && stats_ready))
    else $error("emit read without statistics");
  a_div_idle_go: assert property (@(posedge clk) disable iff (rst)
    div_go |=> !div_done)
    else $error("divider finished right after start");
`endif

endmodule

// ----- src/lnorm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lnorm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lnorm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lnorm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [lnorm_pkg::DVD_W-1:0] dividend,
  input  logic [lnorm_pkg::DVR_W-1:0] divisor,
  output logic                        done,
  output logic [lnorm_pkg::DVD_W-1:0] quotient
);
  import lnorm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W) + 1;

  logic [DVR_W-1:0] dvr;
  logic [DVR_W-1:0] rem;
  logic [DVR_W:0]   rem_sh;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             running;

  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvr      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      rem      <= ge ? DVR_W'(rem_sh - {1'b0, dvr}) : rem_sh[DVR_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule
